// ----- rtl/core/ccws_pkg.sv -----
// Shared types, codes and helpers for the calibrator control word serializer.
// No dependencies; imported by calibrator_control_word_serializer_top and its testbench.
`timescale 1ns / 1ps

package ccws_pkg;

  localparam int unsigned CfgWidth = 15;
  localparam int unsigned ArgWidth = 16;
  localparam int unsigned ProdWidth = 26;          // 65535 * 1000 fits in 26 bits
  localparam int unsigned QuoWidth = 15;           // quotient of 30000 / f

  localparam logic [QuoWidth-1:0] DIV_NUMERATOR = 15'd30000;
  localparam logic [9:0]          KHZ_TO_HZ     = 10'd1000;
  localparam logic [3:0]          FREQ_PREFIX   = 4'hA;
  localparam logic [4:0]          ATT_MAX       = 5'd30;
  localparam logic [4:0]          ATT_SPLIT     = 5'd15;

  // command kinds
  localparam logic [2:0] KIND_SIG_TYPE = 3'd0;
  localparam logic [2:0] KIND_FREQ     = 3'd1;
  localparam logic [2:0] KIND_ATT      = 3'd2;
  localparam logic [2:0] KIND_EXIT     = 3'd3;
  localparam logic [2:0] KIND_STATUS   = 3'd4;

  // result frame codes
  localparam logic [1:0] FRAME_FREQ   = 2'd0;
  localparam logic [1:0] FRAME_ATT    = 2'd1;
  localparam logic [1:0] FRAME_TYPE   = 2'd2;
  localparam logic [1:0] FRAME_STATUS = 2'd3;

  // configuration register indexes
  localparam logic CFG_MIN_FREQ = 1'b0;
  localparam logic CFG_MAX_FREQ = 1'b1;

  localparam logic [CfgWidth-1:0] MIN_FREQ_RESET = 15'd1000;
  localparam logic [CfgWidth-1:0] MAX_FREQ_RESET = 15'd30000;

  localparam logic [4:0] STATUS_EXTERNAL = 5'h10;
  localparam logic [4:0] STATUS_INTERNAL = 5'h1F;
  localparam logic [4:0] STATUS_OFF      = 5'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DIV,
    ST_PACK,
    ST_SHIFT,
    ST_STATUS
  } ccws_state_t;

  // Build the 32-bit frequency word and apply the low-byte bit shuffle.
  function automatic logic [31:0] freq_word(input logic [QuoWidth-1:0] n);
    logic [31:0] w;
    logic [7:0]  lo;
    begin
      w  = {9'd0, FREQ_PREFIX, 1'b0, n, 3'b001};
      lo = w[7:0];
      freq_word = {w[31:8], lo[7:6], 2'b00, lo[5:3], lo[2] | lo[0]};
    end
  endfunction

  function automatic logic [4:0] status_value(input logic enabled, input logic external);
    begin
      if (!enabled) begin
        status_value = STATUS_OFF;
      end else if (external) begin
        status_value = STATUS_EXTERNAL;
      end else begin
        status_value = STATUS_INTERNAL;
      end
    end
  endfunction

endpackage

// ----- rtl/core/calibrator_control_word_serializer_top.sv -----
// Calibrator control word serializer: command in, serial control words out.
// Depends on ccws_pkg for codes, the state type and the word builders.
`timescale 1ns / 1ps

// One command word is taken at a time; in_stall stays high until its last result
// word has been taken. A modulation frequency command scales kHz to Hz with one
// constant multiply, clamps it in the next cycle, then runs a restoring divider
// for 30000 / f, one quotient bit per cycle (skipped when f is zero), packs the
// word and shifts out 32 bits MSB first. An attenuation command loads its 8-bit
// word at once and shifts it out LSB first. Signal type and exit commands send a
// 4-bit frame MSB first followed by one status word; a work status command sends
// the status word alone. Unused kinds are taken and dropped. An output stall holds
// the current result word. The user must write the clamp registers through the cfg
// port only while the block is idle; the block itself does not enforce this.
module calibrator_control_word_serializer_top (
  input  logic                           clk,
  input  logic                           rst,
  // command channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     kind,
  input  logic [ccws_pkg::ArgWidth-1:0]  arg,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     frame,
  output logic                           data_bit,
  output logic [4:0]                     status_code,
  output logic                           last,
  // configuration write port
  input  logic                           cfg_wr_en,
  input  logic                           cfg_index,
  input  logic [ccws_pkg::CfgWidth-1:0]  cfg_data
);

  import ccws_pkg::*;

  ccws_state_t state, state_next;

  logic [CfgWidth-1:0]  min_freq_hz;
  logic [CfgWidth-1:0]  max_freq_hz;
  logic                 radio_pulse_mode;
  logic                 external_exit;
  logic                 enabled;

  logic [ProdWidth-1:0] freq_prod;      // arg * 1000
  logic [CfgWidth-1:0]  divisor;        // clamped frequency in Hz
  logic [QuoWidth-1:0]  dividend;       // numerator bits out, quotient bits in
  logic [CfgWidth-1:0]  remainder;
  logic [3:0]           div_count;

  logic [31:0]          shift_word;
  logic [5:0]           bit_count;      // serial bits still to send
  logic [1:0]           frame_code;
  logic                 msb_first;
  logic                 status_pending;

  logic                 in_take;
  logic                 out_take;
  logic [CfgWidth:0]    rem_shift;
  logic                 rem_fits;
  logic [CfgWidth-1:0]  clamped;
  logic [4:0]           att_idx;
  logic [7:0]           att_word;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // Divider step: shift one numerator bit in, trial subtract.
  assign rem_shift = {remainder, dividend[QuoWidth-1]};
  assign rem_fits  = rem_shift >= {1'b0, divisor};

  // Clamp: lower limit tested first; with crossed limits, values below it take the lower one, all others the upper one.
  always_comb begin
    if (freq_prod < ProdWidth'(min_freq_hz)) begin
      clamped = min_freq_hz;
    end else if (freq_prod > ProdWidth'(max_freq_hz)) begin
      clamped = max_freq_hz;
    end else begin
      clamped = freq_prod[CfgWidth-1:0];
    end
  end

  // Attenuation: saturate at 30, split over the two 4-bit attenuators above 15.
  always_comb begin
    att_idx = (arg > ArgWidth'(ATT_MAX)) ? ATT_MAX : arg[4:0];
    if (att_idx > ATT_SPLIT) begin
      att_word = {4'hF, 4'(att_idx - ATT_SPLIT)};
    end else begin
      att_word = {3'd0, att_idx};
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          case (kind)
            KIND_SIG_TYPE: state_next = ST_SHIFT;
            KIND_FREQ:     state_next = ST_SCALE;
            KIND_ATT:      state_next = ST_SHIFT;
            KIND_EXIT:     state_next = ST_SHIFT;
            KIND_STATUS:   state_next = ST_STATUS;
            default:       state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCALE: begin
        state_next = (clamped == '0) ? ST_PACK : ST_DIV;
      end
      ST_DIV: begin
        if (div_count == '0) begin
          state_next = ST_PACK;
        end
      end
      ST_PACK: begin
        state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (out_take && bit_count == 6'd1) begin
          state_next = status_pending ? ST_STATUS : ST_IDLE;
        end
      end
      ST_STATUS: begin
        if (out_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs: all driven from registers, never from out_stall.
  always_comb begin
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    frame       = frame_code;
    data_bit    = 1'b0;
    status_code = STATUS_OFF;
    last        = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_SHIFT: begin
        out_valid = 1'b1;
        data_bit  = msb_first ? shift_word[31] : shift_word[0];
        last      = (bit_count == 6'd1) && !status_pending;
      end
      ST_STATUS: begin
        out_valid   = 1'b1;
        frame       = FRAME_STATUS;
        status_code = status_value(enabled, external_exit);
        last        = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      min_freq_hz      <= MIN_FREQ_RESET;
      max_freq_hz      <= MAX_FREQ_RESET;
      radio_pulse_mode <= 1'b0;
      external_exit    <= 1'b0;
      enabled          <= 1'b0;
      shift_word       <= '0;
      bit_count        <= '0;
      status_pending   <= 1'b0;
      frame_code       <= FRAME_FREQ;
      msb_first        <= 1'b1;
      div_count        <= '0;
    end else begin
      state <= state_next;

      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MIN_FREQ: min_freq_hz <= cfg_data;
          CFG_MAX_FREQ: max_freq_hz <= cfg_data;
          default:      min_freq_hz <= min_freq_hz;
        endcase
      end

      case (state)
        ST_IDLE: begin
          if (in_take) begin
            case (kind)
              KIND_SIG_TYPE: begin
                radio_pulse_mode <= (arg == ArgWidth'(1));
                shift_word     <= {(arg == ArgWidth'(1)), external_exit, 2'b10, 28'd0};
                bit_count      <= 6'd4;
                frame_code     <= FRAME_TYPE;
                msb_first      <= 1'b1;
                status_pending <= 1'b1;
              end
              KIND_FREQ: begin
                freq_prod <= ProdWidth'(arg) * ProdWidth'(KHZ_TO_HZ);
              end
              KIND_ATT: begin
                shift_word     <= {24'd0, att_word};
                bit_count      <= 6'd8;
                frame_code     <= FRAME_ATT;
                msb_first      <= 1'b0;
                status_pending <= 1'b0;
              end
              KIND_EXIT: begin
                external_exit  <= (arg == ArgWidth'(1));
                shift_word     <= {radio_pulse_mode, (arg == ArgWidth'(1)), 2'b10, 28'd0};
                bit_count      <= 6'd4;
                frame_code     <= FRAME_TYPE;
                msb_first      <= 1'b1;
                status_pending <= 1'b1;
              end
              KIND_STATUS: begin
                enabled   <= (arg == ArgWidth'(1));
                bit_count <= '0;
              end
              default: begin
                bit_count <= bit_count;
              end
            endcase
          end
        end
        ST_SCALE: begin
          // zero frequency: leave the numerator itself as the quotient
          divisor   <= clamped;
          dividend  <= DIV_NUMERATOR;
          remainder <= '0;
          div_count <= 4'(QuoWidth - 1);
        end
        ST_DIV: begin
          remainder <= rem_fits ? CfgWidth'(rem_shift - {1'b0, divisor})
                                : rem_shift[CfgWidth-1:0];
          dividend  <= {dividend[QuoWidth-2:0], rem_fits};
          div_count <= div_count - 4'd1;
        end
        ST_PACK: begin
          shift_word     <= freq_word(dividend);
          bit_count      <= 6'd32;
          frame_code     <= FRAME_FREQ;
          msb_first      <= 1'b1;
          status_pending <= 1'b0;
        end
        ST_SHIFT: begin
          if (out_take) begin
            // advance one bit in the direction of this frame
            shift_word <= msb_first ? {shift_word[30:0], 1'b0} : {1'b0, shift_word[31:1]};
            bit_count  <= bit_count - 6'd1;
          end
        end
        default: begin
          bit_count <= bit_count;
        end
      endcase
    end
  end

endmodule

// ----- test/tb_calibrator_control_word_serializer_top.sv -----
// Self-checking testbench for the calibrator control word serializer: drives commands,
// predicts each serial and status word and checks them in order. Depends on ccws_pkg
// and calibrator_control_word_serializer_top.
`timescale 1ns / 1ps

module tb_calibrator_control_word_serializer_top;
  import ccws_pkg::*;

  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 8;     // time for an ignored command to leave the block
  localparam int TAIL_CYCLES    = 64;    // longer than the slowest command with no stall
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off for the pressure test
  localparam int WATCHDOG_LIMIT = 2000;  // several times the longest quiet stretch
  localparam int BATCH_SIZE     = 28;

  localparam logic [2:0]  KIND_SPARE_LO   = 3'd5;
  localparam logic [2:0]  KIND_SPARE_HI   = 3'd7;
  localparam logic [31:0] HZ_PER_KHZ      = 32'd1000;
  localparam logic [31:0] PERIOD_NUMER    = 32'd30000;
  localparam logic [31:0] WORD_PREFIX     = 32'h0A;
  localparam logic [7:0]  SHUFFLE_LOW     = 8'h0F;
  localparam logic [7:0]  SHUFFLE_KEEP    = 8'hC1;
  localparam logic [4:0]  ATT_CEILING     = 5'd30;
  localparam logic [4:0]  ATT_STEP        = 5'd15;
  localparam logic [7:0]  ATT_UPPER_FULL  = 8'hF0;
  localparam logic [1:0]  CHANNEL_CODE    = 2'b10;
  localparam logic [14:0] CLAMP_LO_RESET  = 15'd1000;
  localparam logic [14:0] CLAMP_HI_RESET  = 15'd30000;
  localparam logic [14:0] CLAMP_FULL      = 15'h7FFF;
  localparam logic [15:0] FLAG_SET        = 16'd1;
  localparam logic [15:0] ARG_FULL        = 16'hFFFF;

  typedef struct packed {
    logic [1:0] frame;
    logic       data_bit;
    logic [4:0] status_code;
    logic       last;
  } ctrl_word_t;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic [2:0]            kind        = KIND_SIG_TYPE;
  logic [ArgWidth-1:0]   arg         = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [1:0]            frame;
  logic                  data_bit;
  logic [4:0]            status_code;
  logic                  last;
  logic                  cfg_wr_en   = 1'b0;
  logic                  cfg_index   = CFG_MIN_FREQ;
  logic [CfgWidth-1:0]   cfg_data    = '0;

  // Predicted calibrator state, mirrored from the accepted commands.
  logic                  pulse_mode;
  logic                  exit_external;
  logic                  output_on;
  logic [CfgWidth-1:0]   clamp_lo_hz;
  logic [CfgWidth-1:0]   clamp_hi_hz;

  ctrl_word_t ctrl_words_due[$];
  int         mismatches  = 0;
  int         quiet_cycles = 0;
  bit         idle_on     = 1'b1;   // random gaps on both channels
  bit         hold_req    = 1'b0;   // ask the receiver for one long hold-off

  calibrator_control_word_serializer_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .arg         (arg),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .frame       (frame),
    .data_bit    (data_bit),
    .status_code (status_code),
    .last        (last),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void queue_ctrl_word(input logic [1:0] f, input logic b,
                                          input logic [4:0] code, input logic l);
    ctrl_word_t w;
    w.frame       = f;
    w.data_bit    = b;
    w.status_code = code;
    w.last        = l;
    ctrl_words_due.push_back(w);
  endfunction

  // Off gives zero; on gives the external or internal exit code.
  function automatic logic [4:0] current_status();
    if (!output_on) begin
      return STATUS_OFF;
    end
    return exit_external ? STATUS_EXTERNAL : STATUS_INTERNAL;
  endfunction

  // Type/channel nibble MSB first, then the parallel status word.
  function automatic void queue_type_and_status();
    logic [3:0] nibble;
    nibble = {pulse_mode, exit_external, CHANNEL_CODE};
    for (int i = 3; i >= 0; i--) begin
      queue_ctrl_word(FRAME_TYPE, nibble[i], STATUS_OFF, 1'b0);
    end
    queue_ctrl_word(FRAME_STATUS, 1'b0, current_status(), 1'b1);
  endfunction

  // Work out every word that one accepted command produces and update the state.
  function automatic void predict_control_words(input logic [2:0] cmd_kind,
                                                input logic [15:0] cmd_arg);
    logic [31:0] hz;
    logic [31:0] period_n;
    logic [31:0] freq_word;
    logic [7:0]  low_byte;
    logic [4:0]  att_idx;
    logic [7:0]  att_word;
    case (cmd_kind)
      KIND_SIG_TYPE: begin
        pulse_mode = (cmd_arg == FLAG_SET);
        queue_type_and_status();
      end
      KIND_EXIT: begin
        exit_external = (cmd_arg == FLAG_SET);
        queue_type_and_status();
      end
      KIND_STATUS: begin
        output_on = (cmd_arg == FLAG_SET);
        queue_ctrl_word(FRAME_STATUS, 1'b0, current_status(), 1'b1);
      end
      KIND_FREQ: begin
        // Lower limit tested first, also when crossed; zero Hz maps to full N.
        hz = cmd_arg * HZ_PER_KHZ;
        if (hz < clamp_lo_hz) begin
          hz = 32'(clamp_lo_hz);
        end else if (hz > clamp_hi_hz) begin
          hz = 32'(clamp_hi_hz);
        end
        period_n  = (hz == 0) ? PERIOD_NUMER : PERIOD_NUMER / hz;
        freq_word = (WORD_PREFIX << 19) | (period_n << 3) | 32'd1;
        low_byte  = freq_word[7:0];
        freq_word[7:0] = ((low_byte >> 2) & SHUFFLE_LOW) | (low_byte & SHUFFLE_KEEP);
        for (int i = 31; i >= 0; i--) begin
          queue_ctrl_word(FRAME_FREQ, freq_word[i], STATUS_OFF, i == 0);
        end
      end
      KIND_ATT: begin
        att_idx  = (cmd_arg > ATT_CEILING) ? ATT_CEILING : cmd_arg[4:0];
        att_word = (att_idx > ATT_STEP) ? (ATT_UPPER_FULL | {3'b000, att_idx - ATT_STEP})
                                        : {3'b000, att_idx};
        for (int i = 0; i < 8; i++) begin
          queue_ctrl_word(FRAME_ATT, att_word[i], STATUS_OFF, i == 7);
        end
      end
      default: begin
        // spare kinds: taken and dropped
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [4:0] want,
                                      input logic [4:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Sample both channels and the register port at every edge; predict on accepted
  // commands before checking so the order within the edge never matters.
  always @(posedge clk) begin : word_monitor
    ctrl_word_t due;
    if (rst) begin
      pulse_mode    = 1'b0;
      exit_external = 1'b0;
      output_on     = 1'b0;
      clamp_lo_hz   = CLAMP_LO_RESET;
      clamp_hi_hz   = CLAMP_HI_RESET;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_MIN_FREQ) begin
          clamp_lo_hz = cfg_data;
        end else begin
          clamp_hi_hz = cfg_data;
        end
      end
      if (in_valid && !in_stall) begin
        predict_control_words(kind, arg);
      end
      if (out_valid && !out_stall) begin
        if (ctrl_words_due.size() == 0) begin
          $error("unexpected result word: frame %0d data_bit %0d status_code %0d last %0d",
                 frame, data_bit, status_code, last);
          mismatches++;
        end else begin
          due = ctrl_words_due.pop_front();
          check_field("frame", 5'(due.frame), 5'(frame));
          check_field("data_bit", 5'(due.data_bit), 5'(data_bit));
          check_field("status_code", due.status_code, status_code);
          check_field("last", 5'(due.last), 5'(last));
        end
      end
    end
  end

  // Abort when neither channel moves a word for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, calm stretches, and one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_receiver
    int span;
    repeat (RESET_CYCLES) @(posedge clk);
    forever begin
      if (hold_req) begin
        // hold the output long enough for the command side to back up as well
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        span = $urandom_range(1, 14);
        repeat (span) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        span = idle_on ? $urandom_range(1, 40) : 4;
        repeat (span) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one command word and return at the edge that takes it. Valid stays high
  // afterwards unless the next call opens a gap, so back-to-back words need no toggle.
  task automatic send_command(input logic [2:0] cmd_kind, input logic [15:0] cmd_arg);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= cmd_kind;
    arg      <= cmd_arg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Pick a command with an argument weighted towards the interesting corners.
  // Spare kinds are sent now and then but do not count as useful.
  task automatic send_random_command(output bit useful);
    logic [2:0]  cmd_kind;
    logic [15:0] cmd_arg;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      cmd_kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      cmd_arg  = 16'($urandom_range(0, ARG_FULL));
    end else begin
      cmd_kind = 3'($urandom_range(KIND_SIG_TYPE, KIND_STATUS));
      roll = $urandom_range(0, 99);
      case (cmd_kind)
        KIND_FREQ: begin
          if (roll < 15)      cmd_arg = '0;
          else if (roll < 65) cmd_arg = 16'($urandom_range(1, 40));
          else if (roll < 85) cmd_arg = 16'($urandom_range(0, ARG_FULL));
          else                cmd_arg = ARG_FULL;
        end
        KIND_ATT: begin
          if (roll < 70)      cmd_arg = 16'($urandom_range(0, 31));
          else if (roll < 85) cmd_arg = 16'($urandom_range(0, ARG_FULL));
          else                cmd_arg = ARG_FULL;
        end
        default: begin
          if (roll < 45)      cmd_arg = FLAG_SET;
          else if (roll < 70) cmd_arg = '0;
          else                cmd_arg = 16'($urandom_range(0, ARG_FULL));
        end
      endcase
    end
    useful = (cmd_kind <= KIND_STATUS);
    send_command(cmd_kind, cmd_arg);
  endtask

  task automatic send_random_batch(input int count);
    int  sent;
    bit  useful;
    sent = 0;
    while (sent < count) begin
      send_random_command(useful);
      if (useful) sent++;
    end
  endtask

  // Drop valid and wait until every predicted word has been taken, then give the
  // block time to finish any command that produced nothing.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ctrl_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reprogram both frequency clamps while the block is idle.
  task automatic program_clamps(input logic [CfgWidth-1:0] lo_hz,
                                input logic [CfgWidth-1:0] hi_hz);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_MIN_FREQ;
    cfg_data  <= lo_hz;
    @(posedge clk);
    cfg_index <= CFG_MAX_FREQ;
    cfg_data  <= hi_hz;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every command kind at its corners, with the reset clamps.
  task automatic test_directed_commands();
    send_command(KIND_STATUS, '0);          // off: zero status code
    send_command(KIND_STATUS, FLAG_SET);    // on, internal exit
    send_command(KIND_EXIT, FLAG_SET);      // external exit
    send_command(KIND_EXIT, 16'd2);         // any flag other than one means internal
    send_command(KIND_SIG_TYPE, FLAG_SET);  // radio pulse
    send_command(KIND_SIG_TYPE, ARG_FULL);  // back to sine
    send_command(KIND_FREQ, '0);            // below the lower clamp
    send_command(KIND_FREQ, 16'd1);
    send_command(KIND_FREQ, 16'd30);        // exactly the upper clamp
    send_command(KIND_FREQ, 16'd31);        // above the upper clamp
    send_command(KIND_FREQ, ARG_FULL);
    send_command(KIND_ATT, '0);
    send_command(KIND_ATT, 16'd15);         // top of the first attenuator
    send_command(KIND_ATT, 16'd16);         // first step into the second one
    send_command(KIND_ATT, 16'd30);
    send_command(KIND_ATT, 16'd31);         // saturates at thirty
    send_command(KIND_ATT, ARG_FULL);
    send_command(KIND_SPARE_LO, ARG_FULL);  // spare kinds: nothing comes out
    send_command(3'd6, '0);
    send_command(KIND_SPARE_HI, FLAG_SET);
    send_command(KIND_STATUS, ARG_FULL);    // off again
  endtask

  // Random commands under a series of clamp settings, extremes included: both zero
  // (zero frequency), both at full scale (quotient of zero), the narrowest range,
  // crossed limits, the widest range, a random pair and finally the reset values.
  task automatic test_random_under_clamps();
    program_clamps('0, '0);
    send_random_batch(BATCH_SIZE);
    program_clamps(CLAMP_FULL, CLAMP_FULL);
    send_random_batch(BATCH_SIZE);
    program_clamps(15'd1, 15'd1);
    send_random_batch(BATCH_SIZE);
    program_clamps(15'd20000, 15'd5000);
    send_random_batch(BATCH_SIZE);
    program_clamps('0, CLAMP_FULL);
    send_random_batch(BATCH_SIZE);
    program_clamps(15'($urandom_range(1, 30000)), 15'($urandom_range(1, 30000)));
    send_random_batch(BATCH_SIZE);
    program_clamps(CLAMP_LO_RESET, CLAMP_HI_RESET);
    send_random_batch(BATCH_SIZE);
  endtask

  // Hold the output for a long stretch while commands keep coming, so the block
  // fills up and has to stall its input.
  task automatic test_output_backpressure();
    drain_results();
    hold_req = 1'b1;
    send_random_batch(10);
    drain_results();
  endtask

  // Finish with both channels running flat out.
  task automatic test_unpaced_tail();
    idle_on = 1'b0;
    send_random_batch(20);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_directed_commands();
    test_random_under_clamps();
    test_output_backpressure();
    test_unpaced_tail();

    // drain, then allow the slowest command's worth of cycles for stray words
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && ctrl_words_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
